FILE: rtl/core/mahxa_pkg.sv
// package: payload types, aes s-box and round function for the xor hash accumulator
package mahxa_pkg;

    localparam int ROUNDS_DEFAULT = 4;
    localparam int CFG_INDEX_W    = 8;
    localparam int WORD_W         = 64;
    localparam int BLOCK_W        = 128;

    typedef struct packed {
        logic [WORD_W-1:0] data_low;
        logic [WORD_W-1:0] data_high;
        logic [WORD_W-1:0] mask_low;
        logic [WORD_W-1:0] mask_high;
        logic              is_last;
    } mahxa_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] tag_low;
        logic [WORD_W-1:0] tag_high;
    } mahxa_out_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] state;
        logic               is_last;
    } mahxa_stage_t;

    localparam logic [CFG_INDEX_W-1:0] REG_ROUND_KEY_LOW  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ROUND_KEY_HIGH = CFG_INDEX_W'(1);

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // shiftrows, subbytes, mixcolumns, addroundkey; byte i sits at bits 8i+7:8i
    function automatic logic [BLOCK_W-1:0] aes_round(input logic [BLOCK_W-1:0] s,
                                                     input logic [BLOCK_W-1:0] k);
        logic [7:0]         t [16];
        logic [BLOCK_W-1:0] res;
        logic [7:0]         a0;
        logic [7:0]         a1;
        logic [7:0]         a2;
        logic [7:0]         a3;
        logic [7:0]         all_x;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4*c] = SBOX[s[8*(r + 4*((c + r) & 3)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0    = t[4*c];
            a1    = t[4*c + 1];
            a2    = t[4*c + 2];
            a3    = t[4*c + 3];
            all_x = a0 ^ a1 ^ a2 ^ a3;
            res[8*(4*c)     +: 8] = a0 ^ all_x ^ xtime(a0 ^ a1) ^ k[8*(4*c)     +: 8];
            res[8*(4*c + 1) +: 8] = a1 ^ all_x ^ xtime(a1 ^ a2) ^ k[8*(4*c + 1) +: 8];
            res[8*(4*c + 2) +: 8] = a2 ^ all_x ^ xtime(a2 ^ a3) ^ k[8*(4*c + 2) +: 8];
            res[8*(4*c + 3) +: 8] = a3 ^ all_x ^ xtime(a3 ^ a0) ^ k[8*(4*c + 3) +: 8];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/mahxa_round_stage.sv
// one registered aes round stage with valid/ready flow control
module mahxa_round_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  mahxa_pkg::mahxa_stage_t        up_data,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output mahxa_pkg::mahxa_stage_t        dn_data,
    input  logic [mahxa_pkg::BLOCK_W-1:0]  round_key
);
    import mahxa_pkg::*;

    logic         valid_reg;
    mahxa_stage_t data_reg;
    mahxa_stage_t data_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        data_next.state   = aes_round(up_data.state, round_key);
        data_next.is_last = up_data.is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/core/masked_aes_xor_hash_accumulator.sv
// top level: masked aes round hash with xor accumulator and tag output register
// the tag register loads when the last block leaves the final round stage
// throughput: one block per cycle unless stalled, one registered aes round per stage
// the accumulator xor is the only feedback; a waiting tag stalls only a last block
// reset: pipeline valids, tag valid, accumulator and round key clear to zero
module masked_aes_xor_hash_accumulator #(
    parameter int ROUNDS = mahxa_pkg::ROUNDS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  mahxa_pkg::mahxa_in_t               in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output mahxa_pkg::mahxa_out_t              out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mahxa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mahxa_pkg::WORD_W-1:0]       cfg_data
);
    import mahxa_pkg::*;

    logic [WORD_W-1:0]  round_key_low_reg;
    logic [WORD_W-1:0]  round_key_high_reg;
    logic [BLOCK_W-1:0] round_key;

    logic               pipe_valid [ROUNDS+1];
    logic               pipe_ready [ROUNDS+1];
    mahxa_stage_t       pipe_data  [ROUNDS+1];

    logic [BLOCK_W-1:0] acc_reg;
    logic [BLOCK_W-1:0] acc_next;
    logic [BLOCK_W-1:0] acc_sum;
    logic               absorb;
    logic               out_valid_reg;
    logic               out_valid_next;
    mahxa_out_t         out_data_reg;

    // configuration
    assign cfg_ready = 1'b1;
    assign round_key = {round_key_high_reg, round_key_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_key_low_reg  <= '0;
            round_key_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROUND_KEY_LOW:  round_key_low_reg  <= cfg_data;
                REG_ROUND_KEY_HIGH: round_key_high_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // whitening with mask and round key
    assign pipe_valid[0]         = in_valid;
    assign in_ready              = pipe_ready[0];
    assign pipe_data[0].state    = {in_data.data_high ^ in_data.mask_high,
                                    in_data.data_low ^ in_data.mask_low} ^ round_key;
    assign pipe_data[0].is_last  = in_data.is_last;

    for (genvar i = 0; i < ROUNDS; i++)
    begin : g_round
        mahxa_round_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (pipe_valid[i]),
            .up_ready  (pipe_ready[i]),
            .up_data   (pipe_data[i]),
            .dn_valid  (pipe_valid[i+1]),
            .dn_ready  (pipe_ready[i+1]),
            .dn_data   (pipe_data[i+1]),
            .round_key (round_key)
        );
    end

    // accumulate; a last block also needs the tag register free
    assign pipe_ready[ROUNDS] = !pipe_data[ROUNDS].is_last || !out_valid_reg || out_ready;
    assign absorb             = pipe_valid[ROUNDS] && pipe_ready[ROUNDS];
    assign acc_sum            = acc_reg ^ pipe_data[ROUNDS].state;

    always_comb
    begin
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (absorb)
        begin
            if (pipe_data[ROUNDS].is_last)
            begin
                acc_next       = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (absorb && pipe_data[ROUNDS].is_last)
        begin
            out_data_reg.tag_low  <= acc_sum[WORD_W-1:0];
            out_data_reg.tag_high <= acc_sum[BLOCK_W-1:WORD_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: bench/tb_masked_aes_xor_hash_accumulator.sv
// testbench: randomized block stream with key changes, tags checked against an aes round predictor
`timescale 1ns / 1ps

module tb_masked_aes_xor_hash_accumulator;
    import mahxa_pkg::*;

    localparam int ROUNDS      = ROUNDS_DEFAULT;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_TOP   = '1;
    localparam logic [WORD_W-1:0] ONES  = '1;
    localparam logic [WORD_W-1:0] ZEROS = '0;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    mahxa_in_t              in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    mahxa_out_t             out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]      cfg_data = '0;

    mahxa_in_t    pending_blocks [$];
    mahxa_out_t   expected_tags [$];
    logic [7:0]   sub_table [256];
    logic [127:0] acc_state;
    logic [127:0] key_state;
    int           burst_left;
    int           gap_left;
    int           stall_mode;
    int           stall_timer;
    int           cycle_count = 0;
    int           errors = 0;
    int           blocks_sent = 0;
    int           tags_expected = 0;
    int           tags_checked = 0;
    int           key_settings = 0;

    masked_aes_xor_hash_accumulator #(.ROUNDS(ROUNDS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // s-box from the field inverse and the affine map
    function automatic logic [7:0] sub_byte(input logic [7:0] a);
        logic [7:0] inv;
        inv = 8'h01;
        for (int i = 0; i < 254; i++)
            inv = gf_mul(inv, a);
        if (a == 8'h00)
            inv = 8'h00;
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
               ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    // byte i of the state sits at bits 8i+7:8i, row i mod 4, column i div 4
    function automatic logic [127:0] enc_round(input logic [127:0] st, input logic [127:0] rk);
        logic [7:0]   sb [16];
        logic [127:0] nx;
        logic [7:0]   a0;
        logic [7:0]   a1;
        logic [7:0]   a2;
        logic [7:0]   a3;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sb[r + 4*c] = sub_table[st[8*(r + 4*((c + r) % 4)) +: 8]];
        for (int c = 0; c < 4; c++)
        begin
            a0 = sb[4*c];
            a1 = sb[4*c + 1];
            a2 = sb[4*c + 2];
            a3 = sb[4*c + 3];
            nx[8*(4*c)     +: 8] = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
            nx[8*(4*c + 1) +: 8] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
            nx[8*(4*c + 2) +: 8] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
            nx[8*(4*c + 3) +: 8] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
        end
        return nx ^ rk;
    endfunction

    function automatic logic [127:0] mix_block(input mahxa_in_t blk, input logic [127:0] key);
        logic [127:0] st;
        st = {blk.data_high ^ blk.mask_high, blk.data_low ^ blk.mask_low} ^ key;
        for (int n = 0; n < ROUNDS; n++)
            st = enc_round(st, key);
        return st;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic report_mismatch(input string field, input int idx,
                                   input logic [WORD_W-1:0] got, input logic [WORD_W-1:0] want);
        $display("mismatch on tag %0d, %s: got %h, expected %h", idx, field, got, want);
        errors++;
    endtask

    task automatic add_block(input logic [WORD_W-1:0] d_lo, input logic [WORD_W-1:0] d_hi,
                             input logic [WORD_W-1:0] m_lo, input logic [WORD_W-1:0] m_hi,
                             input logic last);
        mahxa_in_t blk;
        blk.data_low  = d_lo;
        blk.data_high = d_hi;
        blk.mask_low  = m_lo;
        blk.mask_high = m_hi;
        blk.is_last   = last;
        pending_blocks.push_back(blk);
    endtask

    // random content with some degenerate masks and data
    task automatic add_random_block(input logic last);
        logic [WORD_W-1:0] d_lo;
        logic [WORD_W-1:0] d_hi;
        logic [WORD_W-1:0] m_lo;
        logic [WORD_W-1:0] m_hi;
        d_lo = rand_word();
        d_hi = rand_word();
        case ($urandom_range(0, 15))
            0: begin d_lo = ZEROS; d_hi = ZEROS; end
            1: begin d_lo = ONES;  d_hi = ONES;  end
            default: ;
        endcase
        m_lo = rand_word();
        m_hi = rand_word();
        case ($urandom_range(0, 9))
            0: begin m_lo = ZEROS; m_hi = ZEROS; end
            1: begin m_lo = d_lo;  m_hi = d_hi;  end
            2: begin m_lo = ONES;  m_hi = ONES;  end
            default: ;
        endcase
        add_block(d_lo, d_hi, m_lo, m_hi, last);
    endtask

    task automatic add_message(input int len);
        for (int i = 0; i < len; i++)
            add_random_block(i == len - 1);
    endtask

    function automatic int message_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(9, 40);
        return $urandom_range(1, 8);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_key(input logic [WORD_W-1:0] k_lo, input logic [WORD_W-1:0] k_hi);
        write_reg(REG_ROUND_KEY_LOW, k_lo);
        write_reg(REG_ROUND_KEY_HIGH, k_hi);
        key_settings++;
    endtask

    // wait for every queued block and tag, then let the pipeline empty
    task automatic drain();
        do
            @(posedge clk);
        while (pending_blocks.size() != 0 || in_valid || expected_tags.size() != 0);
        repeat (ROUNDS + 4) @(posedge clk);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            acc_state  = '0;
            key_state  = '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROUND_KEY_LOW:  key_state[63:0]   = cfg_data;
                    REG_ROUND_KEY_HIGH: key_state[127:64] = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                acc_state ^= mix_block(in_data, key_state);
                blocks_sent++;
                if (in_data.is_last)
                begin
                    expected_tags.push_back('{tag_low: acc_state[63:0],
                                              tag_high: acc_state[127:64]});
                    tags_expected++;
                    acc_state = '0;
                end
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_blocks.size() > 0)
                begin
                    in_data  <= pending_blocks.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 60 : 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall mode is redrawn whenever its random timer runs out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_mode  = 0;
            stall_timer = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_tags.size() == 0)
                    report_mismatch("tag_low, no last block pending", tags_checked,
                                    out_data.tag_low, ZEROS);
                else
                begin
                    mahxa_out_t want;
                    want = expected_tags.pop_front();
                    if (out_data.tag_low !== want.tag_low)
                        report_mismatch("tag_low", tags_checked, out_data.tag_low, want.tag_low);
                    if (out_data.tag_high !== want.tag_high)
                        report_mismatch("tag_high", tags_checked, out_data.tag_high,
                                        want.tag_high);
                end
                tags_checked++;
            end
            if (stall_timer == 0)
            begin
                stall_mode  = $urandom_range(0, 2);
                stall_timer = $urandom_range(10, 80);
            end
            else
                stall_timer--;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cycle limit reached with %0d tags outstanding", expected_tags.size());
            $display("tb_masked_aes_xor_hash_accumulator: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [WORD_W-1:0] w_lo;
        logic [WORD_W-1:0] w_hi;
        int                target;
        for (int i = 0; i < 256; i++)
            sub_table[i] = sub_byte(8'(i));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed blocks under the reset key
        add_block(ZEROS, ZEROS, ZEROS, ZEROS, 1'b1);
        add_block(ONES, ONES, ZEROS, ZEROS, 1'b1);
        add_block(ONES, ONES, ONES, ONES, 1'b1);
        w_lo = rand_word();
        w_hi = rand_word();
        add_block(w_lo, w_hi, w_lo, w_hi, 1'b1);
        add_block({16{4'ha}}, {16{4'h5}}, {16{4'h5}}, {16{4'ha}}, 1'b0);
        add_block({16{4'h5}}, {16{4'ha}}, ZEROS, ZEROS, 1'b1);
        add_block(64'h1, 64'h8000_0000_0000_0000, ZEROS, ZEROS, 1'b1);
        add_block(ZEROS, ZEROS, rand_word(), rand_word(), 1'b1);
        add_block(rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);
        add_block(rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);
        add_block(rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);
        add_block(rand_word(), rand_word(), rand_word(), rand_word(), 1'b1);
        drain();

        // all-ones key, plus writes to unmapped indexes that must be ignored
        set_key(ONES, ONES);
        write_reg(REG_SPARE, rand_word());
        write_reg(REG_TOP, rand_word());
        add_block(ZEROS, ZEROS, ZEROS, ZEROS, 1'b1);
        add_block(ONES, ONES, ZEROS, ZEROS, 1'b1);
        add_block(rand_word(), rand_word(), ZEROS, ZEROS, 1'b1);
        add_block(rand_word(), rand_word(), rand_word(), rand_word(), 1'b1);
        add_block(rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);
        add_block(ONES, ZEROS, ZEROS, ONES, 1'b1);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       set_key(rand_word(), rand_word());
                1:       set_key(ZEROS, rand_word());
                2:       set_key(rand_word(), ZEROS);
                3:       set_key(ZEROS, ZEROS);
                4:       set_key(ONES, rand_word());
                default: set_key(rand_word(), rand_word());
            endcase
            target = blocks_sent + 160;
            while (blocks_sent + pending_blocks.size() < target)
            begin
                add_message(message_length());
                // stop adding messages until every queued block and tag is through
                if (phase == 1 && pending_blocks.size() > 80)
                    drain();
            end
            // leave a message open across the next key change
            if (phase == 2)
                for (int i = 0; i < 3; i++)
                    add_random_block(1'b0);
            drain();
        end

        $display("sent %0d blocks forming %0d tags under %0d key settings",
                 blocks_sent, tags_expected, key_settings);
        $display("checked %0d tags, %0d mismatches", tags_checked, errors);
        if (errors == 0)
            $display("tb_masked_aes_xor_hash_accumulator: done, clean");
        else
            $display("tb_masked_aes_xor_hash_accumulator: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mahxa_pkg.sv
rtl/core/mahxa_round_stage.sv
rtl/core/masked_aes_xor_hash_accumulator.sv
bench/tb_masked_aes_xor_hash_accumulator.sv
